@@ hdl/mowd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy window detector package
// Shared constants and types for the occupancy window detector.
// ----------------------------------------------------------------------------
package mowd_pkg;

  // Number of scanned sections (2 to 16).
  localparam int unsigned Sections = 16;
  localparam int unsigned SecW     = (Sections > 1) ? $clog2(Sections) : 1;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegWindowLimit   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOccupiedLimit = 8'd1;
  localparam logic [CfgIdxW-1:0] RegAddr0To3      = 8'd2;
  localparam logic [CfgIdxW-1:0] RegAddr4To7      = 8'd3;
  localparam logic [CfgIdxW-1:0] RegAddr8To11     = 8'd4;
  localparam logic [CfgIdxW-1:0] RegAddr12To15    = 8'd5;

  // Reset values of the configuration registers.
  localparam logic [7:0]  WindowLimitRst   = 8'd50;
  localparam logic [7:0]  OccupiedLimitRst = 8'd45;
  localparam logic [31:0] Addr0To3Rst      = 32'h0403_0201;
  localparam logic [31:0] Addr4To7Rst      = 32'h0807_0605;
  localparam logic [31:0] Addr8To11Rst     = 32'h0C0B_0A09;
  localparam logic [31:0] Addr12To15Rst    = 32'h100F_0E0D;

  localparam logic StateFree     = 1'b0;
  localparam logic StateOccupied = 1'b1;

  // One section's entry in the state memory.
  typedef struct packed {
    logic       occupied;
    logic [7:0] high_count;
    logic [7:0] tick_count;
  } section_entry_t;

endpackage

@@ hdl/mowd_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy window detector channels
// Valid/ready channels for sensor samples, results and register writes.
// ----------------------------------------------------------------------------
interface mowd_sample_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink   (input valid, input sensor_level, output ready);
endinterface

interface mowd_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] next_section;
  logic       event_valid;
  logic [7:0] event_address;
  logic       old_state;
  logic       new_state;

  modport source (output valid, output next_section, output event_valid,
                  output event_address, output old_state, output new_state,
                  input ready);
  modport sink   (input valid, input next_section, input event_valid,
                  input event_address, input old_state, input new_state,
                  output ready);
endinterface

interface mowd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mowd_pkg::CfgIdxW-1:0]   index;
  logic [mowd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/multiplexed_occupancy_window_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexed occupancy window detector
// Per-section sample counting and windowed occupancy judgment with events.
// ----------------------------------------------------------------------------
// Each sample transfer is one scan tick and yields exactly one result. The
// block takes one sample per clock cycle while the result channel does not
// stall it, and the result register is loaded straight from the accepted
// sample; the rate is set by the state memory, which has one read and one
// write per cycle: the entry for the section scanned next is read while the
// current section is written back. Because the scan order is fixed, that
// read is always one section ahead and never hits the entry being written.
// Entries start free with zero counters via per-entry valid bits cleared at
// reset, so no clearing pass is needed. Register writes are taken every cycle.
module multiplexed_occupancy_window_detector_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mowd_sample_if.sink           sample_i,
  mowd_result_if.source         result_o,
  mowd_cfg_if.sink              cfg_i
);

  // Configuration registers.
  logic [7:0]      window_limit_q;
  logic [7:0]      occupied_limit_q;
  logic [3:0][7:0] addr_q [4];

  // State memory and its valid bits.
  mowd_pkg::section_entry_t mem [mowd_pkg::Sections];
  logic [mowd_pkg::Sections-1:0] entry_vld_q;

  logic [mowd_pkg::SecW-1:0]  scan_ptr_q;
  logic [mowd_pkg::SecW-1:0]  scan_ptr_d;
  mowd_pkg::section_entry_t   rd_data_q;
  logic                       rd_vld_q;

  mowd_pkg::section_entry_t   cur_entry;
  mowd_pkg::section_entry_t   wr_entry;
  logic [7:0]                 high_next;
  logic [7:0]                 tick_next;
  logic                       judge;
  logic                       judged;
  logic                       change;
  logic [3:0]                 sec4;

  logic       out_valid_q;
  logic [3:0] next_section_q;
  logic       event_valid_q;
  logic [7:0] event_address_q;
  logic       old_state_q;
  logic       new_state_q;

  logic accept;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_limit_q   <= mowd_pkg::WindowLimitRst;
      occupied_limit_q <= mowd_pkg::OccupiedLimitRst;
      addr_q[0]        <= mowd_pkg::Addr0To3Rst;
      addr_q[1]        <= mowd_pkg::Addr4To7Rst;
      addr_q[2]        <= mowd_pkg::Addr8To11Rst;
      addr_q[3]        <= mowd_pkg::Addr12To15Rst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mowd_pkg::RegWindowLimit:   window_limit_q   <= cfg_i.data[7:0];
        mowd_pkg::RegOccupiedLimit: occupied_limit_q <= cfg_i.data[7:0];
        mowd_pkg::RegAddr0To3:      addr_q[0]        <= cfg_i.data;
        mowd_pkg::RegAddr4To7:      addr_q[1]        <= cfg_i.data;
        mowd_pkg::RegAddr8To11:     addr_q[2]        <= cfg_i.data;
        mowd_pkg::RegAddr12To15:    addr_q[3]        <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // An entry never written since reset reads as free with zero counters.
  always_comb begin
    cur_entry = rd_vld_q ? rd_data_q : '0;
    high_next = cur_entry.high_count + {7'd0, sample_i.sensor_level};
    tick_next = cur_entry.tick_count + 8'd1;
    judge     = tick_next > window_limit_q;
    judged    = ((high_next != 8'd0) && (high_next < occupied_limit_q))
                ? mowd_pkg::StateOccupied : mowd_pkg::StateFree;
    change    = judge && (cur_entry.occupied != judged);
    if (judge) begin
      wr_entry.occupied   = judged;
      wr_entry.high_count = 8'd0;
      wr_entry.tick_count = 8'd0;
    end else begin
      wr_entry.occupied   = cur_entry.occupied;
      wr_entry.high_count = high_next;
      wr_entry.tick_count = tick_next;
    end
    if (scan_ptr_q == mowd_pkg::SecW'(mowd_pkg::Sections - 1)) begin
      scan_ptr_d = '0;
    end else begin
      scan_ptr_d = scan_ptr_q + mowd_pkg::SecW'(1);
    end
    sec4 = 4'(scan_ptr_q);
  end

  // Write back the current section and prefetch the next one.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[scan_ptr_q] <= wr_entry;
      rd_data_q       <= mem[scan_ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      scan_ptr_q  <= '0;
    end else if (accept) begin
      entry_vld_q[scan_ptr_q] <= 1'b1;
      rd_vld_q                <= entry_vld_q[scan_ptr_d];
      scan_ptr_q              <= scan_ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      out_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      next_section_q  <= 4'(scan_ptr_d);
      event_valid_q   <= change;
      event_address_q <= change ? addr_q[sec4[3:2]][sec4[1:0]] : 8'd0;
      old_state_q     <= change ? cur_entry.occupied : mowd_pkg::StateFree;
      new_state_q     <= change ? judged : mowd_pkg::StateFree;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.next_section  = next_section_q;
  assign result_o.event_valid   = event_valid_q;
  assign result_o.event_address = event_address_q;
  assign result_o.old_state     = old_state_q;
  assign result_o.new_state     = new_state_q;

endmodule

@@ bench/multiplexed_occupancy_window_detector_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy window detector core testbench
// Sends sensor samples through the scan, predicts every result with a
// scoreboard that tracks the per-section counters and occupancy flags,
// and checks each result transfer in order. The configuration changes
// between phases, and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module multiplexed_occupancy_window_detector_core_test;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned ModeSwitchA = 620;
  localparam int unsigned ModeSwitchB = 1240;

  // Indexes that select no register.
  localparam logic [mowd_pkg::CfgIdxW-1:0] RegUnusedLow  = 8'd6;
  localparam logic [mowd_pkg::CfgIdxW-1:0] RegUnusedHigh = 8'hFF;

  typedef struct packed {
    logic [3:0] next_section;
    logic       event_valid;
    logic [7:0] event_address;
    logic       old_state;
    logic       new_state;
  } occupancy_result_t;

  class occupancy_board;
    logic [7:0]                window_limit;
    logic [7:0]                occupied_limit;
    logic [31:0]               address_word [4];
    logic [mowd_pkg::SecW-1:0] scan_ptr;
    logic [7:0]                high_count [mowd_pkg::Sections];
    logic [7:0]                tick_count [mowd_pkg::Sections];
    logic                      occupied   [mowd_pkg::Sections];
    occupancy_result_t         expected_q [$];
    int unsigned               failures;

    function new();
      window_limit    = mowd_pkg::WindowLimitRst;
      occupied_limit  = mowd_pkg::OccupiedLimitRst;
      address_word[0] = mowd_pkg::Addr0To3Rst;
      address_word[1] = mowd_pkg::Addr4To7Rst;
      address_word[2] = mowd_pkg::Addr8To11Rst;
      address_word[3] = mowd_pkg::Addr12To15Rst;
      scan_ptr        = '0;
      for (int s = 0; s < mowd_pkg::Sections; s++) begin
        high_count[s] = '0;
        tick_count[s] = '0;
        occupied[s]   = mowd_pkg::StateFree;
      end
      failures = 0;
    endfunction

    function void note_config(logic [mowd_pkg::CfgIdxW-1:0] idx,
                              logic [mowd_pkg::CfgDataW-1:0] data);
      case (idx)
        mowd_pkg::RegWindowLimit:   window_limit    = data[7:0];
        mowd_pkg::RegOccupiedLimit: occupied_limit  = data[7:0];
        mowd_pkg::RegAddr0To3:      address_word[0] = data;
        mowd_pkg::RegAddr4To7:      address_word[1] = data;
        mowd_pkg::RegAddr8To11:     address_word[2] = data;
        mowd_pkg::RegAddr12To15:    address_word[3] = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic level);
      occupancy_result_t want;
      logic              judged;
      int                sec;
      want = '0;
      sec  = int'(scan_ptr);
      if (level) high_count[sec] = high_count[sec] + 8'd1;
      tick_count[sec] = tick_count[sec] + 8'd1;
      if (tick_count[sec] > window_limit) begin
        judged = (high_count[sec] != 8'd0 && high_count[sec] < occupied_limit) ?
                 mowd_pkg::StateOccupied : mowd_pkg::StateFree;
        if (occupied[sec] != judged) begin
          want.event_valid   = 1'b1;
          want.event_address = address_word[sec / 4][8 * (sec % 4) +: 8];
          want.old_state     = occupied[sec];
          want.new_state     = judged;
          occupied[sec]      = judged;
        end
        tick_count[sec] = '0;
        high_count[sec] = '0;
      end
      scan_ptr = (sec == mowd_pkg::Sections - 1) ? '0 : scan_ptr + 1'b1;
      want.next_section = 4'(scan_ptr);
      expected_q.push_back(want);
    endfunction

    function void check_result(occupancy_result_t got);
      occupancy_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.next_section !== want.next_section || got.event_valid !== want.event_valid ||
          got.event_address !== want.event_address || got.old_state !== want.old_state ||
          got.new_state !== want.new_state) begin
        failures++;
        if (failures <= 10)
          $display("wrong result: expected next %h event %b addr %h old %b new %b, %s",
                   want.next_section, want.event_valid, want.event_address,
                   want.old_state, want.new_state,
                   $sformatf("got next %h event %b addr %h old %b new %b",
                             got.next_section, got.event_valid, got.event_address,
                             got.old_state, got.new_state));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mowd_sample_if sample_if ();
  mowd_result_if result_if ();
  mowd_cfg_if    cfg_if ();

  multiplexed_occupancy_window_detector_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  occupancy_board board;
  int unsigned    source_gap_pct;
  int unsigned    sink_stall_pct;
  int unsigned    sent_count;
  int unsigned    level_bias [mowd_pkg::Sections];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("multiplexed_occupancy_window_detector_core: mismatch");
        $finish;
      end
    end
  end

  // Result side: checks every transfer and stalls at random, with one long
  // hold-off early on so that the block backs up into the sample channel.
  initial begin : result_sink
    occupancy_result_t got;
    int unsigned       taken;
    bit                held;
    taken = 0;
    held  = 1'b0;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        got.next_section  = result_if.next_section;
        got.event_valid   = result_if.event_valid;
        got.event_address = result_if.event_address;
        got.old_state     = result_if.old_state;
        got.new_state     = result_if.new_state;
        board.check_result(got);
        taken++;
      end
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        result_if.ready <= 1'b0;
        for (int c = 0; c < LongHold; c++) @(posedge clk_i);
      end
      result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_sample(input logic level);
    if (sent_count < ModeSwitchA) begin
      source_gap_pct = 23;
      sink_stall_pct = 63;
    end else if (sent_count < ModeSwitchB) begin
      source_gap_pct = 63;
      sink_stall_pct = 23;
    end else begin
      source_gap_pct = 0;
      sink_stall_pct = 0;
    end
    while ($urandom_range(99) < source_gap_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid        <= 1'b1;
    sample_if.sensor_level <= level;
    @(posedge clk_i);
    while (sample_if.ready !== 1'b1) @(posedge clk_i);
    board.note_sample(level);
    sent_count++;
  endtask

  // Each section gets a fixed tendency per phase: always low, always high,
  // or a random mix that usually lands inside the occupied band.
  task automatic run_phase(input int unsigned count);
    for (int s = 0; s < mowd_pkg::Sections; s++) begin
      case ($urandom_range(3))
        0: level_bias[s] = 0;
        1: level_bias[s] = 100;
        default: level_bias[s] = $urandom_range(5, 60);
      endcase
    end
    for (int unsigned i = 0; i < count; i++)
      send_sample($urandom_range(99) < level_bias[board.scan_ptr]);
  endtask

  task automatic settle();
    sample_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mowd_pkg::CfgIdxW-1:0] idx,
                           input logic [mowd_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    board.note_config(idx, data);
  endtask

  task automatic configure(input logic [7:0] window, input logic [7:0] occ_limit,
                           input logic [31:0] addr_lo, input logic [31:0] addr_hi,
                           input bit poke_unused);
    write_reg(mowd_pkg::RegWindowLimit, {24'($urandom_range(0, 16777215)), window});
    write_reg(mowd_pkg::RegOccupiedLimit, {24'($urandom_range(0, 16777215)), occ_limit});
    write_reg(mowd_pkg::RegAddr0To3, addr_lo);
    write_reg(mowd_pkg::RegAddr4To7, $urandom());
    write_reg(mowd_pkg::RegAddr8To11, $urandom());
    write_reg(mowd_pkg::RegAddr12To15, addr_hi);
    if (poke_unused) begin
      write_reg(RegUnusedLow, $urandom());
      write_reg(RegUnusedHigh, $urandom());
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    board      = new();
    sent_count = 0;
    source_gap_pct = 23;
    sink_stall_pct = 63;
    rst_ni                 <= 1'b0;
    sample_if.valid        <= 1'b0;
    sample_if.sensor_level <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= '0;
    cfg_if.data            <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: both sensor levels under the reset settings, scan wraps once.
    for (int i = 0; i < 20; i++) send_sample((i % 3) != 0);

    // Reset settings long enough for every section to be judged once.
    run_phase(820);
    settle();

    // Occupied limit zero: everything falls back to free.
    configure(8'd0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    run_phase(40);
    settle();

    // Window limit zero: each tick judges its section on its own sample.
    configure(8'd0, 8'd2, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    run_phase(150);
    settle();

    // Window limit 255 never judges; the counters carry into the next phase.
    configure(8'd255, 8'd255, $urandom(), $urandom(), 1'b0);
    run_phase(300);
    settle();

    configure(8'd1, 8'd255, $urandom(), $urandom(), 1'b0);
    run_phase(100);
    settle();

    configure(8'd254, 8'd1, $urandom(), $urandom(), 1'b0);
    run_phase(100);
    settle();

    configure(8'd3, 8'd2, $urandom(), $urandom(), 1'b0);
    run_phase(100);
    settle();

    for (int p = 0; p < 4; p++) begin
      configure(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)), $urandom(), $urandom(),
                1'b0);
      run_phase(60);
      settle();
    end

    if (board.expected_q.size() != 0) begin
      $display("%0d expected results never arrived", board.expected_q.size());
      board.failures += board.expected_q.size();
    end
    if (board.failures == 0) begin
      $display("multiplexed_occupancy_window_detector_core: match");
    end else begin
      $display("multiplexed_occupancy_window_detector_core: mismatch");
    end
    $finish;
  end

endmodule
